// ===== sv/qs_pkg.sv =====
`default_nettype none
package qs_pkg;
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef struct packed {
        logic cmp_le;
        logic cmp_ge;
    } qs_status_t;
endpackage
`default_nettype wire

// ===== sv/qs_ram.sv =====
`default_nettype none
module qs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/quicksort_engine.sv =====
// quicksort_engine: sorts a set of signed integers in ascending order.
// Input channel (s_valid/s_ready, s_value, s_is_last): one element per
// transaction, one per cycle while loading. Elements beyond MAX_ITEMS are
// dropped; the transaction marked is_last (stored if room) starts the sort.
// The sort is quicksort with the leftmost element as pivot and a stack of
// pending ranges in a RAM. Each range is partitioned by two scans that
// close in from both ends, with a swap for each out-of-place pair, and a
// sorted or reversed set is the worst case for this pivot choice.
// Output channel (m_valid/m_ready, m_sorted_value, m_end_of_set): the set
// is emitted in order, each element read through OUT_RQ and OUT_LD and
// held in OUT_V until m_ready, end_of_set on the greatest. A stall on
// m_ready holds the current result; s_ready stays low from the start of
// the sort until the last result is taken.
// Reset (aresetn low, synchronous) empties the set and idles the engine.
// The element RAM needs no clearing after reset.
`default_nettype none
module quicksort_engine #(
    parameter int MAX_ITEMS  = qs_pkg::MAX_ITEMS_DEF,
    parameter int DATA_WIDTH = qs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_value,
    input  wire logic                         s_is_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_sorted_value,
    output logic                              m_end_of_set
);
    localparam int AW = $clog2(MAX_ITEMS);

    logic          e_we, s_we;
    logic [AW-1:0] e_waddr, e_raddr, s_waddr, s_raddr;
    logic [DATA_WIDTH-1:0] e_wdata, e_rdata, pivot;
    logic [2*AW-1:0] s_wdata, s_rdata;
    logic ld_pivot;
    qs_pkg::qs_status_t st;

    qs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ITEMS)) u_elem (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));

    qs_ram #(.WIDTH(2*AW), .DEPTH(MAX_ITEMS)) u_stack (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));

    qs_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .aclk(aclk), .ld_pivot(ld_pivot), .rdata(e_rdata),
        .pivot(pivot), .status(st));

    qs_ctrl #(.MAX_ITEMS(MAX_ITEMS), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value),
        .s_is_last(s_is_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sorted_value(m_sorted_value), .m_end_of_set(m_end_of_set),
        .e_we(e_we), .e_waddr(e_waddr), .e_wdata(e_wdata), .e_raddr(e_raddr),
        .e_rdata(e_rdata),
        .s_we(s_we), .s_waddr(s_waddr), .s_wdata(s_wdata), .s_raddr(s_raddr),
        .s_rdata(s_rdata), .ld_pivot(ld_pivot), .pivot(pivot), .status(st));
endmodule
`default_nettype wire

// ===== sv/qs_datapath.sv =====
`default_nettype none
module qs_datapath #(
    parameter int DATA_WIDTH = qs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  ld_pivot,
    input  wire logic [DATA_WIDTH-1:0] rdata,
    output logic      [DATA_WIDTH-1:0] pivot,
    output qs_pkg::qs_status_t         status
);
    logic [DATA_WIDTH-1:0] pivot_reg;

    always_ff @(posedge aclk) begin
        if (ld_pivot) begin
            pivot_reg <= rdata;
        end
    end

    assign pivot         = pivot_reg;
    assign status.cmp_le = $signed(rdata) <= $signed(pivot_reg);
    assign status.cmp_ge = $signed(rdata) >= $signed(pivot_reg);
endmodule
`default_nettype wire

// ===== sv/qs_ctrl.sv =====
`default_nettype none
module qs_ctrl #(
    parameter int MAX_ITEMS  = qs_pkg::MAX_ITEMS_DEF,
    parameter int DATA_WIDTH = qs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_value,
    input  wire logic                         s_is_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_sorted_value,
    output logic                              m_end_of_set,
    output logic                              e_we,
    output logic [$clog2(MAX_ITEMS)-1:0]      e_waddr,
    output logic [DATA_WIDTH-1:0]             e_wdata,
    output logic [$clog2(MAX_ITEMS)-1:0]      e_raddr,
    input  wire logic [DATA_WIDTH-1:0]        e_rdata,
    output logic                              s_we,
    output logic [$clog2(MAX_ITEMS)-1:0]      s_waddr,
    output logic [2*$clog2(MAX_ITEMS)-1:0]    s_wdata,
    output logic [$clog2(MAX_ITEMS)-1:0]      s_raddr,
    input  wire logic [2*$clog2(MAX_ITEMS)-1:0] s_rdata,
    output logic                              ld_pivot,
    input  wire logic [DATA_WIDTH-1:0]        pivot,
    input  qs_pkg::qs_status_t                status
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = AW + 1;

    typedef enum logic [3:0] {
        LOAD, POP, POP_W, PIV, LO_RQ, LO_CMP, HI_RQ, HI_CMP,
        SWAP2, FIN1, FIN2, PUSH_LO, PUSH_HI, OUT_RQ, OUT_LD, OUT_V
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg, sp_reg, idx_reg;
    logic [CW-1:0] l_reg, r_reg, lo_reg, hi_reg;
    logic [DATA_WIDTH-1:0] lo_val_reg, hi_val_reg;
    logic signed [DATA_WIDTH-1:0] out_reg;
    logic last_reg, mv_reg;
    logic [CW-1:0] count_next;

    assign s_ready        = (state_reg == LOAD);
    assign m_valid        = mv_reg;
    assign m_sorted_value = out_reg;
    assign m_end_of_set   = last_reg;

    always_comb begin
        e_we       = 1'b0;
        e_waddr    = AW'(count_reg);
        e_wdata    = s_value;
        e_raddr    = AW'(idx_reg);
        s_we       = 1'b0;
        s_waddr    = AW'(sp_reg);
        s_wdata    = {AW'(l_reg), AW'(hi_reg - CW'(1))};
        s_raddr    = AW'(sp_reg - CW'(1));
        ld_pivot   = 1'b0;
        count_next = (count_reg != CW'(MAX_ITEMS)) ? count_reg + CW'(1) : count_reg;
        unique case (state_reg)
            LOAD: begin
                e_we    = s_valid && (count_reg != CW'(MAX_ITEMS));
                // push the whole set as the first range
                s_we    = s_valid && s_is_last && (count_next >= CW'(2));
                s_waddr = '0;
                s_wdata = {{AW{1'b0}}, AW'(count_next - CW'(1))};
            end
            POP_W:   e_raddr = s_rdata[2*AW-1:AW];
            PIV:     ld_pivot = 1'b1;
            LO_RQ:   e_raddr = AW'(lo_reg);
            HI_RQ:   e_raddr = AW'(hi_reg);
            // first half of a swap: the element at hi lands in slot lo
            HI_CMP: begin
                e_we    = !status.cmp_ge && (lo_reg <= hi_reg);
                e_waddr = AW'(lo_reg);
                e_wdata = e_rdata;
            end
            SWAP2: begin
                e_we = 1'b1; e_waddr = AW'(hi_reg); e_wdata = lo_val_reg;
            end
            FIN1: begin
                e_we = 1'b1; e_waddr = AW'(l_reg); e_wdata = hi_val_reg;
            end
            FIN2: begin
                e_we = 1'b1; e_waddr = AW'(hi_reg); e_wdata = pivot;
            end
            PUSH_LO: s_we = (hi_reg > l_reg + CW'(1));
            PUSH_HI: begin
                s_we    = (r_reg > hi_reg + CW'(1));
                s_wdata = {AW'(hi_reg + CW'(1)), AW'(r_reg)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LOAD;
            count_reg <= '0;
            sp_reg    <= '0;
            mv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                LOAD: if (s_valid) begin
                    count_reg <= count_next;
                    if (s_is_last) begin
                        idx_reg <= '0;
                        if (count_next >= CW'(2)) begin
                            sp_reg    <= CW'(1);
                            state_reg <= POP;
                        end else begin
                            state_reg <= OUT_RQ;
                        end
                    end
                end
                POP: begin
                    if (sp_reg == '0) begin
                        idx_reg <= '0; state_reg <= OUT_RQ;
                    end else begin
                        sp_reg <= sp_reg - CW'(1);
                        state_reg <= POP_W;
                    end
                end
                POP_W: begin
                    l_reg  <= CW'(s_rdata[2*AW-1:AW]);
                    r_reg  <= CW'(s_rdata[AW-1:0]);
                    lo_reg <= CW'(s_rdata[2*AW-1:AW]) + CW'(1);
                    hi_reg <= CW'(s_rdata[AW-1:0]);
                    state_reg <= PIV;
                end
                PIV: state_reg <= LO_RQ;
                LO_RQ: state_reg <= (lo_reg > r_reg) ? HI_RQ : LO_CMP;
                LO_CMP: begin
                    if (status.cmp_le) begin
                        lo_reg <= lo_reg + CW'(1);
                        state_reg <= LO_RQ;
                    end else begin
                        lo_val_reg <= e_rdata;
                        state_reg <= HI_RQ;
                    end
                end
                HI_RQ: begin
                    // hi reached the pivot slot: the pivot swaps with itself
                    if (hi_reg <= l_reg) begin
                        hi_val_reg <= pivot;
                        state_reg <= FIN1;
                    end else begin
                        state_reg <= HI_CMP;
                    end
                end
                HI_CMP: begin
                    if (status.cmp_ge) begin
                        hi_reg <= hi_reg - CW'(1);
                        state_reg <= HI_RQ;
                    end else begin
                        hi_val_reg <= e_rdata;
                        state_reg <= (lo_reg <= hi_reg) ? SWAP2 : FIN1;
                    end
                end
                SWAP2: state_reg <= LO_RQ;
                FIN1: state_reg <= FIN2;
                FIN2: state_reg <= PUSH_LO;
                PUSH_LO: begin
                    if (hi_reg > l_reg + CW'(1)) sp_reg <= sp_reg + CW'(1);
                    state_reg <= PUSH_HI;
                end
                PUSH_HI: begin
                    if (r_reg > hi_reg + CW'(1)) sp_reg <= sp_reg + CW'(1);
                    state_reg <= POP;
                end
                OUT_RQ: state_reg <= OUT_LD;
                OUT_LD: begin
                    out_reg   <= e_rdata;
                    last_reg  <= (idx_reg + CW'(1) == count_reg);
                    idx_reg   <= idx_reg + CW'(1);
                    mv_reg    <= 1'b1;
                    state_reg <= OUT_V;
                end
                OUT_V: begin
                    if (m_ready) begin
                        mv_reg <= 1'b0;
                        if (last_reg) begin
                            count_reg <= '0; state_reg <= LOAD;
                        end else begin
                            state_reg <= OUT_RQ;
                        end
                    end
                end
                default: state_reg <= LOAD;
            endcase
        end
    end

    property p_no_in_during_out;
        @(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready;
    endproperty
    a_no_in_during_out: assert property (p_no_in_during_out)
        else $error("input accepted while results pending");
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= CW'(MAX_ITEMS)) else $error("range stack overflow");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ITEMS)) else $error("element count overflow");
endmodule
`default_nettype wire

// ===== dv/tb_quicksort_engine.sv =====
`default_nettype none
class sort_scoreboard;
    logic signed [31:0] pending_set[$];
    logic signed [31:0] sorted_q[$];
    logic               last_q[$];
    int                 errors;

    function new();
        errors = 0;
    endfunction

    // Store the element if there is room; on is_last sort the set and queue the results.
    function void note_element(logic signed [31:0] v, logic last);
        logic signed [31:0] t;
        int n;
        if (pending_set.size() < qs_pkg::MAX_ITEMS_DEF)
            pending_set.push_back(v);
        if (!last)
            return;
        n = pending_set.size();
        for (int i = 1; i < n; i++) begin
            t = pending_set[i];
            for (int j = i; j > 0 && pending_set[j-1] > t; j--) begin
                pending_set[j] = pending_set[j-1];
                pending_set[j-1] = t;
            end
        end
        for (int i = 0; i < n; i++) begin
            sorted_q.push_back(pending_set[i]);
            last_q.push_back(i == n - 1);
        end
        pending_set.delete();
    endfunction

    function void check_result(logic signed [31:0] v, logic eos);
        logic signed [31:0] ev;
        logic el;
        if (sorted_q.size() == 0) begin
            $error("unexpected result sorted_value=%0d end_of_set=%0b", v, eos);
            errors++;
            return;
        end
        ev = sorted_q.pop_front();
        el = last_q.pop_front();
        if (v !== ev) begin
            $error("sorted_value expected %0d actual %0d", ev, v);
            errors++;
        end
        if (eos !== el) begin
            $error("end_of_set expected %0b actual %0b", el, eos);
            errors++;
        end
    endfunction
endclass

module tb_quicksort_engine;
    localparam int WATCHDOG_LIMIT = 200000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_value = '0;
    logic               s_is_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_sorted_value;
    logic               m_end_of_set;

    sort_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    quicksort_engine uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value), .s_is_last(s_is_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sorted_value(m_sorted_value), .m_end_of_set(m_end_of_set)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_element(s_value, s_is_last);
            if (m_valid && m_ready)
                sb.check_result(m_sorted_value, m_end_of_set);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver stalls at random, except during the calm stretch.
    always @(negedge aclk)
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);

    // Hold valid after the transaction; the next call replaces or drops it.
    task automatic send_element(logic signed [31:0] v, logic last);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value(int mode);
        case (mode)
            0: return $urandom_range(7);
            1: return $signed(32'h8000_0000 + $urandom_range(3));
            2: return $signed(32'h7fff_ffff - $urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(int n, int shape);
        logic signed [31:0] v;
        for (int i = 0; i < n; i++) begin
            case (shape)
                0: v = rand_value($urandom_range(3));
                1: v = $signed(i * 1000 - 5);
                2: v = $signed(-i * 997);
                3: v = 42;
                default: v = $urandom;
            endcase
            send_element(v, i == n - 1);
        end
    endtask

    initial begin
        int sent;
        int n;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // Directed: extremes, single element, duplicates, sorted, reversed.
        send_element(32'sh7fff_ffff, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(0, 1'b0);
        send_element(-1, 1'b1);
        send_element(5, 1'b1);
        send_set(4, 3);
        send_set(5, 1);
        send_set(5, 2);
        send_set(2, 0);
        sent = 21;
        // Store full: overflow elements are dropped, the last still starts the sort.
        send_set(70, 4);
        sent += 70;
        calm = 1'b1;
        send_set(30, 0);
        calm = 1'b0;
        sent += 30;
        while (sent < 480) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 12);
            send_set(n, $urandom_range(9) < 6 ? 4 : $urandom_range(3));
            sent += n;
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.sorted_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.sorted_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/qs_pkg.sv
sv/qs_ram.sv
sv/quicksort_engine.sv
sv/qs_datapath.sv
sv/qs_ctrl.sv
dv/tb_quicksort_engine.sv
